/* sv/rau_pkg.sv */
// rau_pkg: shared types and constants for the rational arithmetic unit.
// No dependencies; compiled first.
package rau_pkg;

	localparam int OPERAND_BITS_DEF = 16;
	localparam int RES_NUM_BITS     = 32;
	localparam int RES_DEN_BITS     = 31;

	typedef enum logic [1:0] {
		KIND_ADD = 2'd0,
		KIND_SUB = 2'd1,
		KIND_MUL = 2'd2,
		KIND_DIV = 2'd3
	} kind_t;

	// Status from the GCD engine to the top level.
	typedef struct packed {
		logic done;  // one-cycle pulse, GCD value is valid from here on
		logic odd;   // GCD sits at an odd place of the remainder chain
	} gcd_stat_t;

endpackage

/* sv/rau_in_if.sv */
// rau_in_if: operation channel (valid/ready plus operand payload).
// Depends on rau_pkg.
interface rau_in_if #(
	parameter int OPERAND_BITS = rau_pkg::OPERAND_BITS_DEF
);
	import rau_pkg::*;

	logic                    valid;
	logic                    ready;
	kind_t                   kind;
	logic [OPERAND_BITS-1:0] a_num;
	logic [OPERAND_BITS-1:0] a_den;
	logic [OPERAND_BITS-1:0] b_num;
	logic [OPERAND_BITS-1:0] b_den;

	modport source (output valid, kind, a_num, a_den, b_num, b_den, input ready);
	modport sink   (input valid, kind, a_num, a_den, b_num, b_den, output ready);

endinterface

/* sv/rau_out_if.sv */
// rau_out_if: result channel (valid/ready plus reduced fraction and error flag).
// Depends on rau_pkg.
interface rau_out_if;
	import rau_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [RES_NUM_BITS-1:0] res_num;
	logic [RES_DEN_BITS-1:0] res_den;
	logic                    error;

	modport source (output valid, res_num, res_den, error, input ready);
	modport sink   (input valid, res_num, res_den, error, output ready);

endinterface

/* sv/rau_mul.sv */
// rau_mul: unsigned shift-add multiplier, one multiplier bit per cycle.
// Depends on rau_pkg.
module rau_mul #(
	parameter int W = rau_pkg::OPERAND_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [W-1:0]   a,
	input  logic [W-1:0]   b,
	output logic [2*W-1:0] prod,
	output logic           done
);
	import rau_pkg::*;

	localparam int PW = 2 * W;
	localparam int CW = $clog2(W + 1);

	logic [PW-1:0] mc_q;
	logic [W-1:0]  mp_q;
	logic [PW-1:0] acc_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			// pulse as busy falls, once the last step is registered
			done_q <= !start && busy_q && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// multiplicand shifts up, multiplier shifts out at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			mc_q  <= {{W{1'b0}}, a};
			mp_q  <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (mp_q[0]) begin
				acc_q <= acc_q + mc_q;
			end
			mc_q <= {mc_q[PW-2:0], 1'b0};
			mp_q <= {1'b0, mp_q[W-1:1]};
		end
	end

	assign prod = acc_q;
	assign done = done_q;

endmodule

/* sv/rau_gcd.sv */
// rau_gcd: Euclidean GCD on magnitudes; each remainder is found by aligning
// the divisor one bit per cycle, then shift-subtracting back down.
// Depends on rau_pkg (gcd_stat_t).
module rau_gcd #(
	parameter int W = rau_pkg::OPERAND_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [2*W-1:0]      a,
	input  logic [2*W-1:0]      b,
	output logic [2*W-1:0]      g,
	output rau_pkg::gcd_stat_t  stat
);
	import rau_pkg::*;

	localparam int PW = 2 * W;
	localparam int KW = $clog2(PW);

	typedef enum logic [1:0] {
		G_IDLE,
		G_CHECK,
		G_ALIGN,
		G_SUB
	} gstate_t;

	gstate_t       state_q;
	logic [PW-1:0] x_q;
	logic [PW-1:0] y_q;
	logic [PW-1:0] d_q;
	logic [KW-1:0] k_q;
	logic          par_q;
	logic          done_q;
	logic [PW-1:0] rem;
	logic          ge;

	assign ge  = (x_q >= d_q);
	assign rem = ge ? (x_q - d_q) : x_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= G_IDLE;
			x_q     <= '0;
			y_q     <= '0;
			d_q     <= '0;
			k_q     <= '0;
			par_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			// chain ends when the latest remainder is zero
			done_q <= !start && (state_q == G_CHECK) && (y_q == '0);
			if (start) begin
				x_q     <= a;
				y_q     <= b;
				par_q   <= 1'b1;
				state_q <= G_CHECK;
			end else begin
				case (state_q)
					G_IDLE: begin
					end
					G_CHECK: begin
						if (y_q == '0) begin
							state_q <= G_IDLE;
						end else begin
							d_q     <= y_q;
							k_q     <= '0;
							state_q <= G_ALIGN;
						end
					end
					G_ALIGN: begin
						if ({d_q, 1'b0} <= {1'b0, x_q}) begin
							d_q <= {d_q[PW-2:0], 1'b0};
							k_q <= k_q + 1'b1;
						end else begin
							state_q <= G_SUB;
						end
					end
					G_SUB: begin
						if (k_q == '0) begin
							// remainder done: shift the chain along
							x_q     <= y_q;
							y_q     <= rem;
							par_q   <= ~par_q;
							state_q <= G_CHECK;
						end else begin
							x_q <= rem;
							d_q <= {1'b0, d_q[PW-1:1]};
							k_q <= k_q - 1'b1;
						end
					end
					default: state_q <= G_IDLE;
				endcase
			end
		end
	end

	// after termination x holds the last nonzero remainder
	assign g         = x_q;
	assign stat.done = done_q;
	assign stat.odd  = ~par_q;

endmodule

/* sv/rau_div.sv */
// rau_div: two restoring dividers sharing one divisor, one quotient bit
// per cycle each. Depends on rau_pkg.
module rau_div #(
	parameter int W = rau_pkg::OPERAND_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [2*W-1:0] n,
	input  logic [2*W-1:0] m,
	input  logic [2*W-1:0] dv,
	output logic [2*W-1:0] qn,
	output logic [2*W-1:0] qm,
	output logic           done
);
	import rau_pkg::*;

	localparam int PW = 2 * W;
	localparam int CW = $clog2(PW + 1);

	logic [PW-1:0] rn_q;
	logic [PW-1:0] rm_q;
	logic [PW-1:0] qn_q;
	logic [PW-1:0] qm_q;
	logic [PW-1:0] dv_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [PW:0]   tn;
	logic [PW:0]   tm;
	logic [PW:0]   sn;
	logic [PW:0]   sm;
	logic          bn;
	logic          bm;

	assign tn = {rn_q, qn_q[PW-1]};
	assign tm = {rm_q, qm_q[PW-1]};
	assign bn = (tn >= {1'b0, dv_q});
	assign bm = (tm >= {1'b0, dv_q});
	assign sn = tn - {1'b0, dv_q};
	assign sm = tm - {1'b0, dv_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			// pulse as busy falls, once the last step is registered
			done_q <= !start && busy_q && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(PW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// dividend bits leave at the top, quotient bits enter at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			rn_q <= '0;
			rm_q <= '0;
			qn_q <= n;
			qm_q <= m;
			dv_q <= dv;
		end else if (busy_q) begin
			rn_q <= bn ? sn[PW-1:0] : tn[PW-1:0];
			rm_q <= bm ? sm[PW-1:0] : tm[PW-1:0];
			qn_q <= {qn_q[PW-2:0], bn};
			qm_q <= {qm_q[PW-2:0], bm};
		end
	end

	assign qn   = qn_q;
	assign qm   = qm_q;
	assign done = done_q;

endmodule

/* sv/rational_arith_unit.sv */
// rational_arith_unit: top level, one fraction operation per transfer.
// Depends on rau_pkg, rau_in_if, rau_out_if, rau_mul, rau_gcd, rau_div.
//
// Takes one operation (add, subtract, multiply, divide) on two fractions per
// input transfer and returns one reduced fraction per output transfer. Work is
// bit-serial: three shift-add multipliers form the cross products, the SUM and
// SIGN states combine signs and take magnitudes, the GCD engine runs Euclid,
// aligning the divisor and shift-subtracting for each remainder until it sees
// a zero remainder, and two shared-divisor restoring dividers reduce numerator
// and denominator. The time an item takes is set mostly by the length of the
// remainder chain in the GCD engine; an error item skips GCD and division.
// One item is in flight at a time; a finished result sits in the output
// register, and the next item is taken as soon as the computation has been
// handed to it.
// The GCD follows a truncating remainder, so its sign alternates along the
// chain; that sign lands on the numerator or the denominator and is not
// normalized. A zero unreduced denominator (which covers dividing by a zero
// fraction and 0/0) gives error = 1 with a 0/0 result. Results wider than the
// output fields wrap.
module rational_arith_unit #(
	parameter int OPERAND_BITS = rau_pkg::OPERAND_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	rau_in_if.sink    item,
	rau_out_if.source result
);
	import rau_pkg::*;

	localparam int W  = OPERAND_BITS;
	localparam int PW = 2 * W;       // product magnitude width
	localparam int SW = PW + 1;      // signed sum width
	localparam int XW = (PW + 1 > RES_NUM_BITS) ? PW + 1 : RES_NUM_BITS;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SUM,
		ST_SIGN,
		ST_GCD,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t state_q;

	// captured operands
	kind_t         kind_q;
	logic [W-1:0]  an_q;
	logic [W-1:0]  ad_q;
	logic [W-1:0]  bn_q;
	logic [W-1:0]  bd_q;

	// signed unreduced fraction, then sign/magnitude form
	logic [SW-1:0] num_q;
	logic [SW-1:0] den_q;
	logic [PW-1:0] nmag_q;
	logic [PW-1:0] dmag_q;
	logic          sn_q;
	logic          sd_q;
	logic          err_q;

	logic          mul_start_q;
	logic          gcd_start_q;
	logic          div_start_q;

	// output register
	logic                    out_valid_q;
	logic [RES_NUM_BITS-1:0] res_num_q;
	logic [RES_DEN_BITS-1:0] res_den_q;
	logic                    res_err_q;

	// operand magnitudes
	logic [W-1:0]  an_mag;
	logic [W-1:0]  ad_mag;
	logic [W-1:0]  bn_mag;
	logic [W-1:0]  bd_mag;
	logic [W-1:0]  m0_b;
	logic          is_mul;

	logic [PW-1:0] p0;
	logic [PW-1:0] p1;
	logic [PW-1:0] p2;
	logic          d0;
	logic          d1;
	logic          d2;

	logic [SW-1:0] v0;
	logic [SW-1:0] v1;
	logic [SW-1:0] v2;
	logic [SW-1:0] num_n;
	logic [SW-1:0] den_n;
	logic [SW-1:0] num_neg;
	logic [SW-1:0] den_neg;

	logic [PW-1:0] g;
	gcd_stat_t     gstat;
	logic [PW-1:0] qn;
	logic [PW-1:0] qd;
	logic          div_done;

	logic          flip;
	logic [XW-1:0] qn_x;
	logic [XW-1:0] qd_x;
	logic [XW-1:0] rn_x;
	logic [XW-1:0] rd_x;

	assign an_mag = an_q[W-1] ? (~an_q + 1'b1) : an_q;
	assign ad_mag = ad_q[W-1] ? (~ad_q + 1'b1) : ad_q;
	assign bn_mag = bn_q[W-1] ? (~bn_q + 1'b1) : bn_q;
	assign bd_mag = bd_q[W-1] ? (~bd_q + 1'b1) : bd_q;
	assign is_mul = (kind_q == KIND_MUL);
	assign m0_b   = is_mul ? bn_mag : bd_mag;

	// p0 = an * (bn for multiply, else bd); p1 = bn * ad; p2 = ad * bd
	rau_mul #(.W(W)) u_mul0 (
		.clk(clk), .arst_n(arst_n), .start(mul_start_q),
		.a(an_mag), .b(m0_b), .prod(p0), .done(d0)
	);
	rau_mul #(.W(W)) u_mul1 (
		.clk(clk), .arst_n(arst_n), .start(mul_start_q),
		.a(bn_mag), .b(ad_mag), .prod(p1), .done(d1)
	);
	rau_mul #(.W(W)) u_mul2 (
		.clk(clk), .arst_n(arst_n), .start(mul_start_q),
		.a(ad_mag), .b(bd_mag), .prod(p2), .done(d2)
	);

	// put the operand signs back on the products
	always_comb begin
		logic s0;
		logic s1;
		logic s2;
		s0 = an_q[W-1] ^ (is_mul ? bn_q[W-1] : bd_q[W-1]);
		s1 = bn_q[W-1] ^ ad_q[W-1];
		s2 = ad_q[W-1] ^ bd_q[W-1];
		v0 = s0 ? (SW'(0) - {1'b0, p0}) : {1'b0, p0};
		v1 = s1 ? (SW'(0) - {1'b0, p1}) : {1'b0, p1};
		v2 = s2 ? (SW'(0) - {1'b0, p2}) : {1'b0, p2};
		case (kind_q)
			KIND_ADD: begin
				num_n = v0 + v1;
				den_n = v2;
			end
			KIND_SUB: begin
				num_n = v0 - v1;
				den_n = v2;
			end
			KIND_MUL: begin
				num_n = v0;
				den_n = v2;
			end
			default: begin
				num_n = v0;
				den_n = v1;
			end
		endcase
	end

	assign num_neg = SW'(0) - num_q;
	assign den_neg = SW'(0) - den_q;

	rau_gcd #(.W(W)) u_gcd (
		.clk(clk), .arst_n(arst_n), .start(gcd_start_q),
		.a(nmag_q), .b(dmag_q), .g(g), .stat(gstat)
	);

	rau_div #(.W(W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start_q),
		.n(nmag_q), .m(dmag_q), .dv(g),
		.qn(qn), .qm(qd), .done(div_done)
	);

	// GCD carries the denominator's sign at odd chain positions, the
	// numerator's at even ones; the other field takes the sign product.
	assign flip = sn_q ^ sd_q;
	assign qn_x = {{(XW-PW){1'b0}}, qn};
	assign qd_x = {{(XW-PW){1'b0}}, qd};
	assign rn_x = (flip && gstat.odd)  ? (XW'(0) - qn_x) : qn_x;
	assign rd_x = (flip && !gstat.odd) ? (XW'(0) - qd_x) : qd_x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mul_start_q <= 1'b0;
			gcd_start_q <= 1'b0;
			div_start_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// one-cycle start pulses for the serial units
			mul_start_q <= (state_q == ST_IDLE) && item.valid;
			gcd_start_q <= (state_q == ST_SIGN) && (den_q != '0);
			div_start_q <= (state_q == ST_GCD) && gstat.done;
			// a waiting result leaves unless FIN reloads the register
			if (out_valid_q && result.ready && state_q != ST_FIN) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (item.valid) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (d0 && d1 && d2) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					state_q <= ST_SIGN;
				end
				ST_SIGN: begin
					if (den_q == '0) begin
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_GCD;
					end
				end
				ST_GCD: begin
					if (gstat.done) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					// wait for the output register to free up
					if (!out_valid_q || result.ready) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers, steered by the state
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && item.valid) begin
			kind_q <= item.kind;
			an_q   <= item.a_num;
			ad_q   <= item.a_den;
			bn_q   <= item.b_num;
			bd_q   <= item.b_den;
		end
		if (state_q == ST_SUM) begin
			num_q <= num_n;
			den_q <= den_n;
		end
		if (state_q == ST_SIGN) begin
			sn_q   <= num_q[SW-1];
			sd_q   <= den_q[SW-1];
			nmag_q <= num_q[SW-1] ? num_neg[PW-1:0] : num_q[PW-1:0];
			dmag_q <= den_q[SW-1] ? den_neg[PW-1:0] : den_q[PW-1:0];
			err_q  <= (den_q == '0);
		end
		if (state_q == ST_FIN && (!out_valid_q || result.ready)) begin
			if (err_q) begin
				res_num_q <= '0;
				res_den_q <= '0;
				res_err_q <= 1'b1;
			end else begin
				res_num_q <= rn_x[RES_NUM_BITS-1:0];
				res_den_q <= rd_x[RES_DEN_BITS-1:0];
				res_err_q <= 1'b0;
			end
		end
	end

	assign item.ready     = (state_q == ST_IDLE);
	assign result.valid   = out_valid_q;
	assign result.res_num = res_num_q;
	assign result.res_den = res_den_q;
	assign result.error   = res_err_q;

endmodule
